### hdl/hcbp_pkg.sv
// Shared types, codes and sizes of the Huffman code bit packer.
`timescale 1ns / 1ps
`default_nettype none
package hcbp_pkg;

   localparam int SYMBOLS      = 256;
   localparam int MAX_CODE_LEN = 32;

   localparam int KIND_W   = 2;
   localparam int SYMBOL_W = 8;
   localparam int CODE_W   = 32;
   localparam int LEN_W    = 6;
   localparam int BYTE_W   = 8;
   localparam int BIT_CNT_W = 3;

   // Largest length a table entry can hold.
   localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   // Packing word: one partial byte plus one full code.
   localparam int ACC_W = CODE_W + BYTE_W;
   // Enough to count the bytes a single code can complete.
   localparam int BYTE_CNT_W = LEN_W - BIT_CNT_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

   typedef struct packed {
      logic [LEN_W-1:0]  code_length;
      logic [CODE_W-1:0] code_bits;
   } hcbp_table_entry_type;

   // Work handed from the front end to the packer.
   typedef struct packed {
      logic              is_flush;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_length;
   } hcbp_work_type;

endpackage
`default_nettype wire

### hdl/hcbp_channels.sv
// Request and response channel interfaces of the Huffman code bit packer.
`timescale 1ns / 1ps
`default_nettype none
interface hcbp_req_if import hcbp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [SYMBOL_W-1:0] symbol;
   logic [CODE_W-1:0]   code_bits;
   logic [LEN_W-1:0]    code_length;

   modport source (output valid, output kind, output symbol, output code_bits,
                   output code_length, input ready);
   modport sink (input valid, input kind, input symbol, input code_bits,
                 input code_length, output ready);
endinterface

interface hcbp_rsp_if import hcbp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

### hdl/huffman_code_bit_packer_core.sv
// Top level of the Huffman code bit packer: front end, work queue and packer.
`timescale 1ns / 1ps
`default_nettype none
// The packer takes one request beat per cycle: a load writes one entry of the
// 256-entry code table, an encode appends that entry's code bits to the
// output stream least significant bit first, and a flush emits the partly
// filled byte padded with zeros. Every completed byte leaves as one response
// beat, and the final beat caused by a request carries last. A request beat
// is accepted every cycle while the two-entry work queue has room; the table
// read is registered in the front end. In the packer an encode or flush
// makes zero to four bytes, and the single response register issues them one
// byte per cycle while the response side is ready; the next item is taken
// once the current one has issued its final byte. Loads and requests of
// the unused kind retire in the front end and cost the packer nothing. The
// table needs no clearing pass: each entry has a valid bit that reset clears,
// and an entry that was never loaded has length zero and emits nothing.
module huffman_code_bit_packer_core import hcbp_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   hcbp_req_if.sink   req,
   hcbp_rsp_if.source rsp
);

   hcbp_work_type push_data;
   logic          push_valid;
   logic          push_ready;
   hcbp_work_type pop_data;
   logic          pop_valid;
   logic          pop_ready;

   // Table lookup and classification of request beats.
   hcbp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   // The queue lets table lookups run ahead while the packer drains bytes.
   hcbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   // Bit packing and byte output.
   hcbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_data  (pop_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp       (rsp)
   );

endmodule
`default_nettype wire

### hdl/hcbp_front.sv
// Front end: accepts request beats, owns the code table and classifies items.
`timescale 1ns / 1ps
`default_nettype none
module hcbp_front import hcbp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   hcbp_req_if.sink     req,
   output hcbp_work_type push_data,
   output logic         push_valid,
   input  wire logic    push_ready
);

   hcbp_table_entry_type table_mem [SYMBOLS];
   logic [SYMBOLS-1:0]   table_valid_ff, table_valid_in;

   hcbp_table_entry_type rd_entry_ff;
   logic                 rd_valid_ff;

   logic                 stage_valid_ff, stage_valid_in;
   logic [KIND_W-1:0]    stage_kind_ff;

   logic                 accept;
   logic                 stage_free;
   logic [LEN_W-1:0]     sat_len;
   logic [CODE_W-1:0]    len_mask;
   logic [SYMBOL_W-1:0]  sym_idx;

   assign sym_idx = req.symbol;

   // Loads and unknown kinds retire in the stage; only encodes and flushes
   // need a queue slot.
   assign push_valid = stage_valid_ff &&
                       (stage_kind_ff == KIND_ENCODE || stage_kind_ff == KIND_FLUSH);
   assign stage_free = !stage_valid_ff || !push_valid || push_ready;
   assign req.ready  = stage_free;
   assign accept     = req.valid && stage_free;

   always_comb begin
      sat_len = (req.code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : req.code_length;
      for (int i = 0; i < CODE_W; i++) begin
         len_mask[i] = (LEN_W'(i) < sat_len);
      end
   end

   always_comb begin
      table_valid_in = table_valid_ff;
      if (accept && req.kind == KIND_LOAD) begin
         table_valid_in[sym_idx] = 1'b1;
      end
      stage_valid_in = stage_valid_ff;
      if (stage_free) begin
         stage_valid_in = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_valid_ff <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         table_valid_ff <= table_valid_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Table memory: one write and one registered read per cycle. A read in the
   // cycle after a load of the same entry already sees the new value.
   always_ff @(posedge clock) begin
      if (accept && req.kind == KIND_LOAD) begin
         table_mem[sym_idx] <= '{code_length: sat_len,
                                 code_bits: req.code_bits & len_mask};
      end
      if (accept) begin
         rd_entry_ff   <= table_mem[sym_idx];
         rd_valid_ff   <= table_valid_ff[sym_idx];
         stage_kind_ff <= req.kind;
      end
   end

   // An entry that was never loaded behaves as length zero.
   always_comb begin
      push_data.is_flush    = (stage_kind_ff == KIND_FLUSH);
      push_data.code_bits   = rd_valid_ff ? rd_entry_ff.code_bits : '0;
      push_data.code_length = rd_valid_ff ? rd_entry_ff.code_length : '0;
   end

endmodule
`default_nettype wire

### hdl/hcbp_queue.sv
// Short work queue that decouples the front end from the packer.
`timescale 1ns / 1ps
`default_nettype none
module hcbp_queue import hcbp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire hcbp_work_type push_data,
   input  wire logic          push_valid,
   output logic               push_ready,
   output hcbp_work_type      pop_data,
   output logic               pop_valid,
   input  wire logic          pop_ready
);

   hcbp_work_type            slots [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // The depth is a power of two, so the pointers wrap on their own.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### hdl/hcbp_back.sv
// Back end: packs code bits into bytes and drives the response channel.
`timescale 1ns / 1ps
`default_nettype none
module hcbp_back import hcbp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire hcbp_work_type pop_data,
   input  wire logic          pop_valid,
   output logic               pop_ready,
   hcbp_rsp_if.source         rsp
);

   logic [BYTE_W-1:0]     pending_ff, pending_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [CODE_W-1:0]     work_ff, work_in;
   logic [BYTE_CNT_W-1:0] work_cnt_ff, work_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     rsp_byte_ff;
   logic                  rsp_last_ff;

   logic                  emit;
   logic [ACC_W-1:0]      acc;
   logic [ACC_W-1:0]      acc_rest;
   logic [LEN_W-1:0]      total;
   logic [BYTE_CNT_W-1:0] n_bytes;

   assign emit = (work_cnt_ff != '0) && (!rsp_valid_ff || rsp.ready);
   // Take the next item once the current one has issued its final byte.
   assign pop_ready = (work_cnt_ff == '0) ||
                      (work_cnt_ff == BYTE_CNT_W'(1) && emit);

   always_comb begin
      acc      = (ACC_W'(pop_data.code_bits) << bit_cnt_ff) | ACC_W'(pending_ff);
      total    = LEN_W'(bit_cnt_ff) + pop_data.code_length;
      n_bytes  = total[LEN_W-1:BIT_CNT_W];
      acc_rest = acc >> {n_bytes, 3'b000};
   end

   always_comb begin
      pending_in  = pending_ff;
      bit_cnt_in  = bit_cnt_ff;
      work_in     = work_ff;
      work_cnt_in = work_cnt_ff;
      if (emit) begin
         work_in     = work_ff >> BYTE_W;
         work_cnt_in = work_cnt_ff - 1'b1;
      end
      if (pop_valid && pop_ready) begin
         if (pop_data.is_flush) begin
            if (bit_cnt_ff != '0) begin
               work_in     = CODE_W'(pending_ff);
               work_cnt_in = BYTE_CNT_W'(1);
               pending_in  = '0;
               bit_cnt_in  = '0;
            end
         end else begin
            pending_in = acc_rest[BYTE_W-1:0];
            bit_cnt_in = total[BIT_CNT_W-1:0];
            if (n_bytes != '0) begin
               work_in     = acc[CODE_W-1:0];
               work_cnt_in = n_bytes;
            end
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         bit_cnt_ff   <= '0;
         work_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         bit_cnt_ff   <= bit_cnt_in;
         work_cnt_ff  <= work_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (emit) begin
         rsp_byte_ff <= work_ff[BYTE_W-1:0];
         rsp_last_ff <= (work_cnt_ff == BYTE_CNT_W'(1));
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = rsp_byte_ff;
   assign rsp.last     = rsp_last_ff;

endmodule
`default_nettype wire
